>>> rtl/rsfp_pkg.sv
// Package for the robot status frame parser: shared types, codes and constants.
// Also holds the CRC-16/CCITT-FALSE byte update and the field layout table.
// Depends on nothing; the modules of the block use it by scoped names.
package rsfp_pkg;

  // Frame geometry.
  localparam logic [5:0] LEGACY_FRAME_BYTES = 6'd24;
  localparam logic [5:0] V2_FRAME_BYTES     = 6'd34;

  // Byte positions used by the frame checks.
  localparam logic [5:0] XOR_LAST_IDX   = 6'd21;
  localparam logic [5:0] XSUM_IDX       = 6'd22;
  localparam logic [5:0] CRC_FIRST_IDX  = 6'd1;
  localparam logic [5:0] CRC_LAST_IDX   = 6'd30;
  localparam logic [5:0] CRC_HI_IDX     = 6'd31;
  localparam logic [5:0] CRC_LO_IDX     = 6'd32;
  localparam logic [5:0] VERSION_IDX    = 6'd1;
  localparam logic [5:0] FTYPE_IDX      = 6'd2;
  localparam logic [5:0] PLEN_IDX       = 6'd3;
  localparam logic [5:0] SEQ_IDX        = 6'd4;
  localparam logic [5:0] TICK_IDX       = 6'd6;
  localparam logic [5:0] LEGACY_BASE    = 6'd1;
  localparam logic [5:0] V2_BASE        = 6'd10;

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FTYPE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN    = 3'd5;

  // Field identifiers.
  localparam logic [3:0] FID_STOP    = 4'd0;
  localparam logic [3:0] FID_VX      = 4'd1;
  localparam logic [3:0] FID_VOLT    = 4'd10;
  localparam logic [3:0] FID_VERSION = 4'd11;
  localparam logic [3:0] FID_FTYPE   = 4'd12;
  localparam logic [3:0] FID_PLEN    = 4'd13;
  localparam logic [3:0] FID_SEQ     = 4'd14;
  localparam logic [3:0] FID_TICK    = 4'd15;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FRAME = 2'd1,
    ST_BAD_FIELD = 2'd2,
    ST_BAD_SUM   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    E_IDLE,
    E_FETCH,
    E_ACC,
    E_OUT,
    E_ERR
  } emit_state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] header;
    logic [7:0] tail;
    logic [7:0] version;
    logic [7:0] ftype;
    logic [7:0] plen;
  } cfg_t;

  // Handed from the receive side to the emitter when a frame completes.
  typedef struct packed {
    logic    valid;
    logic    v2;
    status_e status;
  } frame_done_t;

  // Where a field lives in the frame store and how it is formatted.
  typedef struct packed {
    logic [5:0] addr;
    logic [1:0] nbytes_m1;
    logic       sext;
  } field_info_t;

  // One byte through the CRC, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Field layout for both frame formats.
  function automatic field_info_t field_info(input logic [3:0] id, input logic v2);
    field_info_t fi;
    logic [5:0]  base;
    base         = v2 ? V2_BASE : LEGACY_BASE;
    fi.addr      = base;
    fi.nbytes_m1 = 2'd0;
    fi.sext      = 1'b0;
    case (id) inside
      [FID_VX:FID_VOLT]: begin
        fi.addr      = base + {1'b0, id, 1'b0} - 6'd1;
        fi.nbytes_m1 = 2'd1;
        fi.sext      = 1'b1;
      end
      FID_VERSION: fi.addr = VERSION_IDX;
      FID_FTYPE:   fi.addr = FTYPE_IDX;
      FID_PLEN:    fi.addr = PLEN_IDX;
      FID_SEQ: begin
        fi.addr      = SEQ_IDX;
        fi.nbytes_m1 = 2'd1;
      end
      FID_TICK: begin
        fi.addr      = TICK_IDX;
        fi.nbytes_m1 = 2'd3;
      end
      default: fi.addr = base;
    endcase
    return fi;
  endfunction

endpackage

>>> rtl/rsfp_byte_if.sv
// Input channel of the frame parser: one received byte per beat.
// Valid/ready handshake; no dependencies.
interface rsfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/rsfp_result_if.sv
// Output channel of the frame parser: one decoded field or error per beat.
// Valid/ready handshake; no dependencies.
interface rsfp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  field_id;
  logic [31:0] field_value;
  logic        last_of_frame;

  modport source (output valid, output status, output field_id, output field_value,
                  output last_of_frame, input ready);
  modport sink   (input valid, input status, input field_id, input field_value,
                  input last_of_frame, output ready);
endinterface

>>> rtl/rsfp_frame_store.sv
// Frame byte store: 34 x 8 synchronous memory, one write and one read port.
// Read data is registered. Uses rsfp_pkg.
module rsfp_frame_store (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [5:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic [5:0] raddr_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [rsfp_pkg::V2_FRAME_BYTES];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rsfp_frame_rx.sv
// Receive side of the frame parser: byte count, running XOR and CRC, check bytes.
// Writes each byte into the frame store and judges the frame on its last byte.
// Uses rsfp_pkg and rsfp_byte_if.
module rsfp_frame_rx (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rsfp_byte_if.sink             byte_in,
  input  logic                  emit_idle_i,
  input  rsfp_pkg::cfg_t        cfg_i,
  output logic                  mem_we_o,
  output logic [5:0]            mem_waddr_o,
  output logic [7:0]            mem_wdata_o,
  output rsfp_pkg::frame_done_t done_o
);

  logic [5:0]  cnt_q;
  logic [15:0] crc_q;
  logic [7:0]  xor_q;
  // Copies of the bytes the checks need; written before they are read.
  logic [7:0]  hdr_q, ver_q, ftype_q, plen_q, xsum_q, crc_hi_q, crc_lo_q;

  logic        accept;
  logic [5:0]  len;
  logic        restart;
  logic [5:0]  idx;
  logic [15:0] crc_in, crc_d;
  logic [7:0]  xor_in, xor_d;
  logic        is_last;
  logic        bad_frame, bad_field, bad_sum;
  rsfp_pkg::status_e status;

  assign byte_in.ready = emit_idle_i;
  assign accept        = byte_in.valid && byte_in.ready;

  // Frame position; a count at or past the frame length starts a new frame.
  assign len     = cfg_i.mode ? rsfp_pkg::V2_FRAME_BYTES : rsfp_pkg::LEGACY_FRAME_BYTES;
  assign restart = (cnt_q >= len);
  assign idx     = restart ? 6'd0 : cnt_q;
  assign crc_in  = restart ? rsfp_pkg::CRC_INIT : crc_q;
  assign xor_in  = restart ? 8'h00 : xor_q;
  assign is_last = (idx == len - 6'd1);

  // Running checksums over their byte windows.
  always_comb begin
    crc_d = crc_in;
    xor_d = xor_in;
    if (idx >= rsfp_pkg::CRC_FIRST_IDX && idx <= rsfp_pkg::CRC_LAST_IDX) begin
      crc_d = rsfp_pkg::crc_byte(crc_in, byte_in.rx_byte);
    end
    if (idx <= rsfp_pkg::XOR_LAST_IDX) begin
      xor_d = xor_in ^ byte_in.rx_byte;
    end
  end

  // Frame checks in priority order; they only matter on the last byte.
  always_comb begin
    bad_frame = (hdr_q != cfg_i.header) || (byte_in.rx_byte != cfg_i.tail);
    bad_field = (ver_q != cfg_i.version) || (ftype_q != cfg_i.ftype) ||
                (plen_q != cfg_i.plen);
    bad_sum   = cfg_i.mode ? (crc_q != {crc_hi_q, crc_lo_q}) : (xor_q != xsum_q);
    if (bad_frame) begin
      status = rsfp_pkg::ST_BAD_FRAME;
    end else if (cfg_i.mode && bad_field) begin
      status = rsfp_pkg::ST_BAD_FIELD;
    end else if (bad_sum) begin
      status = rsfp_pkg::ST_BAD_SUM;
    end else begin
      status = rsfp_pkg::ST_OK;
    end
  end

  assign done_o.valid  = accept && is_last;
  assign done_o.v2     = cfg_i.mode;
  assign done_o.status = status;

  assign mem_we_o    = accept;
  assign mem_waddr_o = idx;
  assign mem_wdata_o = byte_in.rx_byte;

  // Count and checksum registers; all return to reset after a frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= rsfp_pkg::CRC_INIT;
      xor_q <= '0;
    end else if (accept) begin
      if (is_last) begin
        cnt_q <= '0;
        crc_q <= rsfp_pkg::CRC_INIT;
        xor_q <= '0;
      end else begin
        cnt_q <= idx + 6'd1;
        crc_q <= crc_d;
        xor_q <= xor_d;
      end
    end
  end

  // Check byte captures.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (idx == 6'd0)                    hdr_q    <= byte_in.rx_byte;
      if (idx == rsfp_pkg::VERSION_IDX)   ver_q    <= byte_in.rx_byte;
      if (idx == rsfp_pkg::FTYPE_IDX)     ftype_q  <= byte_in.rx_byte;
      if (idx == rsfp_pkg::PLEN_IDX)      plen_q   <= byte_in.rx_byte;
      if (idx == rsfp_pkg::XSUM_IDX)      xsum_q   <= byte_in.rx_byte;
      if (idx == rsfp_pkg::CRC_HI_IDX)    crc_hi_q <= byte_in.rx_byte;
      if (idx == rsfp_pkg::CRC_LO_IDX)    crc_lo_q <= byte_in.rx_byte;
    end
  end

  // The count always points inside the store.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < rsfp_pkg::V2_FRAME_BYTES)
    else $error("byte count ran past the frame store");

endmodule

>>> rtl/rsfp_emitter.sv
// Result sequencer: reads each field's bytes of a good frame back from the frame store,
// formats the value and holds it in the output register. Uses rsfp_pkg, rsfp_result_if.
module rsfp_emitter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rsfp_pkg::frame_done_t done_i,
  output logic [5:0]            rd_addr_o,
  input  logic [7:0]            rd_data_i,
  output logic                  idle_o,
  rsfp_result_if.source         result_out
);

  rsfp_pkg::emit_state_e state_q, state_d;
  rsfp_pkg::status_e     status_q, status_d;
  logic                  v2_q, v2_d;
  logic [3:0]            fid_q, fid_d;
  logic [1:0]            bsel_q, bsel_d;
  logic [31:0]           acc_q, acc_d;

  logic        out_valid_q;
  logic [1:0]  out_status_q, out_status_d;
  logic [3:0]  out_fid_q, out_fid_d;
  logic [31:0] out_value_q, out_value_d;
  logic        out_last_q, out_last_d;
  logic        out_load;
  logic        out_free;

  rsfp_pkg::field_info_t fi;
  logic        last_field;
  logic [31:0] value;

  assign fi         = rsfp_pkg::field_info(fid_q, v2_q);
  assign rd_addr_o  = fi.addr + {4'b0, bsel_q};
  assign last_field = (fid_q == (v2_q ? rsfp_pkg::FID_TICK : rsfp_pkg::FID_VOLT));
  assign out_free   = !out_valid_q || result_out.ready;
  assign idle_o     = (state_q == rsfp_pkg::E_IDLE);

  // Big-endian bytes gathered in acc_q, widened to 32 bits.
  always_comb begin
    case (fi.nbytes_m1)
      2'd0:    value = {24'h0, acc_q[7:0]};
      2'd1:    value = fi.sext ? {{16{acc_q[15]}}, acc_q[15:0]} : {16'h0, acc_q[15:0]};
      default: value = acc_q;
    endcase
  end

  // Sequencer: fetch, accumulate, then present one beat per field, or one error beat.
  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    v2_d         = v2_q;
    fid_d        = fid_q;
    bsel_d       = bsel_q;
    acc_d        = acc_q;
    out_load     = 1'b0;
    out_status_d = rsfp_pkg::ST_OK;
    out_fid_d    = fid_q;
    out_value_d  = value;
    out_last_d   = last_field;
    unique case (state_q)
      rsfp_pkg::E_IDLE: begin
        if (done_i.valid) begin
          v2_d     = done_i.v2;
          status_d = done_i.status;
          fid_d    = rsfp_pkg::FID_STOP;
          bsel_d   = 2'd0;
          state_d  = (done_i.status == rsfp_pkg::ST_OK) ? rsfp_pkg::E_FETCH
                                                        : rsfp_pkg::E_ERR;
        end
      end
      rsfp_pkg::E_FETCH: begin
        state_d = rsfp_pkg::E_ACC;
      end
      rsfp_pkg::E_ACC: begin
        acc_d = {acc_q[23:0], rd_data_i};
        if (bsel_q == fi.nbytes_m1) begin
          state_d = rsfp_pkg::E_OUT;
        end else begin
          bsel_d  = bsel_q + 2'd1;
          state_d = rsfp_pkg::E_FETCH;
        end
      end
      rsfp_pkg::E_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (last_field) begin
            state_d = rsfp_pkg::E_IDLE;
          end else begin
            fid_d   = fid_q + 4'd1;
            bsel_d  = 2'd0;
            state_d = rsfp_pkg::E_FETCH;
          end
        end
      end
      rsfp_pkg::E_ERR: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = status_q;
          out_fid_d    = rsfp_pkg::FID_STOP;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          state_d      = rsfp_pkg::E_IDLE;
        end
      end
      default: state_d = rsfp_pkg::E_IDLE;
    endcase
  end

  // Sequencer control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rsfp_pkg::E_IDLE;
      status_q <= rsfp_pkg::ST_OK;
      v2_q     <= 1'b0;
      fid_q    <= '0;
      bsel_q   <= '0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      v2_q     <= v2_d;
      fid_q    <= fid_d;
      bsel_q   <= bsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Output register: holds a beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_fid_q    <= out_fid_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
    end
  end

  assign result_out.valid         = out_valid_q;
  assign result_out.status        = out_status_q;
  assign result_out.field_id      = out_fid_q;
  assign result_out.field_value   = out_value_q;
  assign result_out.last_of_frame = out_last_q;

  // A frame only completes while the emitter is idle and all earlier beats are loaded.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i.valid |-> state_q == rsfp_pkg::E_IDLE)
    else $error("frame completed while results still pending");

  // An error beat is the only beat of its frame.
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != rsfp_pkg::ST_OK) |->
      (out_last_q && out_fid_q == rsfp_pkg::FID_STOP && out_value_q == 32'h0))
    else $error("malformed error beat");

  // Byte select never passes the field's width.
  a_bsel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rsfp_pkg::E_ACC |-> bsel_q <= fi.nbytes_m1)
    else $error("byte select beyond field width");

  // Reads stay inside the frame store.
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rsfp_pkg::E_FETCH |-> rd_addr_o < rsfp_pkg::V2_FRAME_BYTES)
    else $error("frame store read out of range");

endmodule

>>> rtl/robot_status_frame_parser.sv
// Top level of the robot status frame parser: configuration registers and wiring.
// Uses rsfp_pkg, rsfp_byte_if, rsfp_result_if, rsfp_frame_rx, rsfp_frame_store, rsfp_emitter.
//
// Bytes are taken one per cycle into a 34-byte frame store while the emitter is idle,
// with no earlier frame's fields left to emit; after the last byte of a frame the input
// stalls while the emitter reads the fields back through the store's single read port,
// fetching and then accumulating each stored byte and giving one result beat per field;
// a failed frame gives its single error beat instead. The store needs no clearing pass
// after reset, since every byte read back was written earlier in the same frame.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; indexes beyond
// the register list are ignored.
module robot_status_frame_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rsfp_byte_if.sink                      byte_in,
  rsfp_result_if.source                  result_out,
  input  logic                           cfg_we_i,
  input  logic [rsfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_wdata_i
);

  rsfp_pkg::cfg_t        cfg_q;
  rsfp_pkg::frame_done_t done;
  logic                  emit_idle;
  logic                  mem_we;
  logic [5:0]            mem_waddr;
  logic [7:0]            mem_wdata;
  logic [5:0]            mem_raddr;
  logic [7:0]            mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= 1'b1;
      cfg_q.header  <= 8'd123;
      cfg_q.tail    <= 8'd125;
      cfg_q.version <= 8'd2;
      cfg_q.ftype   <= 8'd1;
      cfg_q.plen    <= 8'd21;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsfp_pkg::CFG_MODE:    cfg_q.mode    <= cfg_wdata_i[0];
        rsfp_pkg::CFG_HEADER:  cfg_q.header  <= cfg_wdata_i;
        rsfp_pkg::CFG_TAIL:    cfg_q.tail    <= cfg_wdata_i;
        rsfp_pkg::CFG_VERSION: cfg_q.version <= cfg_wdata_i;
        rsfp_pkg::CFG_FTYPE:   cfg_q.ftype   <= cfg_wdata_i;
        rsfp_pkg::CFG_PLEN:    cfg_q.plen    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rsfp_frame_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_in     (byte_in),
    .emit_idle_i (emit_idle),
    .cfg_i       (cfg_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .done_o      (done)
  );

  rsfp_frame_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rsfp_emitter u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .done_i     (done),
    .rd_addr_o  (mem_raddr),
    .rd_data_i  (mem_rdata),
    .idle_o     (emit_idle),
    .result_out (result_out)
  );

endmodule
